>>> src/conv_weight_gradient_macros.svh
// assertion helpers used by cwg_back
`ifndef CONV_WEIGHT_GRADIENT_MACROS_SVH
`define CONV_WEIGHT_GRADIENT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CWG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwg assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CWG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwg assertion failed");

`endif

>>> src/cwg_pkg.sv
package cwg_pkg;

	// parameter defaults
	localparam int MAX_DIM_DEF    = 64;
	localparam int MAX_KERNEL_DEF = 7;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF  = 48;

	// fixed field widths
	localparam int CFG_W     = 7;
	localparam int KS_W      = 3;
	localparam int CFG_IDX_W = 3;
	localparam int COL_W     = 6;
	localparam int TAP_W     = 3;

	// item queue between front and back
	localparam int QDEPTH = 4;
	localparam int QP_W   = 2;
	localparam int QC_W   = 3;

	// register reset values
	localparam logic [KS_W-1:0]  KS_RST   = 3'd3;
	localparam logic [KS_W-1:0]  ST_RST   = 3'd1;
	localparam logic [CFG_W-1:0] DIM_RST  = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL = 3'd0,
		REG_STRIDE = 3'd1,
		REG_IN_W   = 3'd2,
		REG_IN_H   = 3'd3,
		REG_OUT_W  = 3'd4,
		REG_OUT_H  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_LOAD_IN = 2'd0,
		KIND_LOAD_OG = 2'd1,
		KIND_RUN     = 2'd2,
		KIND_CLEAR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_LOAD_IN,
		OP_LOAD_OG,
		OP_RUN,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MUL,
		S_ADD,
		S_EMIT_RD,
		S_EMIT_WR,
		S_ERR
	} state_t;

	typedef struct packed {
		logic [KS_W-1:0]  kernel_size;
		logic [KS_W-1:0]  stride;
		logic [CFG_W-1:0] in_width;
		logic [CFG_W-1:0] in_height;
		logic [CFG_W-1:0] out_width;
		logic [CFG_W-1:0] out_height;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		op_t              op;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] row;
	} head_t;

endpackage

>>> src/cwg_front.sv
module cwg_front
	import cwg_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [COL_W-1:0]      col,
	input  logic [COL_W-1:0]      row,
	input  logic [DATA_WIDTH-1:0] value,
	output head_t                 head,
	output logic [DATA_WIDTH-1:0] head_value,
	input  logic                  pop
);

	logic [1:0]            op_q  [QDEPTH];
	logic [COL_W-1:0]      col_q [QDEPTH];
	logic [COL_W-1:0]      row_q [QDEPTH];
	logic [DATA_WIDTH-1:0] val_q [QDEPTH];
	logic [QP_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [QC_W-1:0]       cnt_q;
	logic                  accept, in_range, is_load, push;
	op_t                   op;

	// classify the incoming beat
	always_comb begin
		case (kind)
			KIND_LOAD_IN: op = OP_LOAD_IN;
			KIND_LOAD_OG: op = OP_LOAD_OG;
			KIND_RUN:     op = OP_RUN;
			default:      op = OP_CLEAR;
		endcase
	end

	assign in_stall = (cnt_q == QC_W'(QDEPTH));
	assign accept   = in_valid && !in_stall;
	assign in_range = (int'(col) < MAX_DIM) && (int'(row) < MAX_DIM);
	assign is_load  = (op == OP_LOAD_IN) || (op == OP_LOAD_OG);
	// loads beyond the storage are dropped here
	assign push     = accept && (!is_load || in_range);

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
			cnt_q <= cnt_q + QC_W'(push) - QC_W'(pop);
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= op;
			col_q[wr_ptr_q] <= col;
			row_q[wr_ptr_q] <= row;
			val_q[wr_ptr_q] <= value;
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.op    = op_t'(op_q[rd_ptr_q]);
	assign head.col   = col_q[rd_ptr_q];
	assign head.row   = row_q[rd_ptr_q];
	assign head_value = val_q[rd_ptr_q];

endmodule

>>> src/cwg_back.sv
`include "conv_weight_gradient_macros.svh"

module cwg_back
	import cwg_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  head_t                 head,
	input  logic [DATA_WIDTH-1:0] head_value,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TAP_W-1:0]      tap_col,
	output logic [TAP_W-1:0]      tap_row,
	output logic [ACC_WIDTH-1:0]  gradient,
	output logic                  status,
	output logic                  last
);

	localparam int DIM_W  = $clog2(MAX_DIM);
	localparam int MA_W   = 2 * DIM_W;
	localparam int MDEPTH = 1 << MA_W;
	localparam int NACC   = MAX_KERNEL * MAX_KERNEL;
	localparam int KI_W   = (NACC > 1) ? $clog2(NACC) : 1;
	localparam int PW     = 2 * DATA_WIDTH;
	localparam int SW     = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
	localparam int CO_W   = CFG_W + 4;
	localparam int RW     = CFG_W + 5;
	localparam logic signed [SW-1:0] ACC_HI =
		{{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_LO =
		{{(SW - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};

	// storage
	logic signed [DATA_WIDTH-1:0] in_mem  [MDEPTH];
	logic signed [DATA_WIDTH-1:0] og_mem  [MDEPTH];
	logic signed [ACC_WIDTH-1:0]  acc_mem [NACC];
	logic [NACC-1:0]              acc_vld_q;

	state_t                       state_q, state_d;
	logic [CFG_W-1:0]             x_q, y_q;
	logic [TAP_W-1:0]             cx_q, cy_q;
	logic signed [DATA_WIDTH-1:0] in_rd_s1, og_rd_s1;
	logic                         oob_s1;
	logic signed [PW-1:0]         prod_s2;
	logic signed [ACC_WIDTH-1:0]  acc_rd_q;
	logic                         acc_rv_q;
	logic                         out_valid_q, status_q, last_q;
	logic [TAP_W-1:0]             tap_col_q, tap_row_q;
	logic [ACC_WIDTH-1:0]         gradient_q;

	logic [KS_W-2:0]              offs;
	logic [KS_W-1:0]              kl;
	logic [CFG_W-1:0]             x_end, y_end;
	logic                         walk_empty, tap_last, bad_cfg, rule_ok, bad_run;
	logic signed [RW-1:0]         ra, rr, rp;
	logic signed [CO_W-1:0]       ix, iy;
	logic                         oob;
	logic [MA_W-1:0]              ld_addr, in_addr, og_addr;
	logic [KI_W-1:0]              acc_addr;
	logic signed [ACC_WIDTH-1:0]  acc_val, acc_sat;
	logic signed [SW-1:0]         acc_sum;
	logic                         out_free, out_ld;

	// run geometry
	assign offs       = cfg.kernel_size[KS_W-1:1];
	assign kl         = cfg.kernel_size - KS_W'(1);
	assign x_end      = cfg.out_width - CFG_W'(offs) - CFG_W'(1);
	assign y_end      = cfg.out_height - CFG_W'(offs) - CFG_W'(1);
	assign walk_empty = ((CFG_W + 1)'(cfg.out_width) <= (CFG_W + 1)'({offs, 1'b0})) ||
		((CFG_W + 1)'(cfg.out_height) <= (CFG_W + 1)'({offs, 1'b0}));
	assign tap_last   = (cx_q == kl) && (cy_q == kl);

	// size rule: trunc((iw - offs) / st) >= ow - 2*offs, without a divider
	always_comb begin
		ra = $signed(RW'(cfg.in_width)) - $signed(RW'(offs));
		rr = $signed(RW'(cfg.out_width)) - $signed(RW'({offs, 1'b0}));
		rp = rr * $signed(RW'(cfg.stride));
		rule_ok = ra[RW-1] ? (ra > rp - $signed(RW'(cfg.stride))) : (ra >= rp);
		bad_cfg = (cfg.kernel_size == '0) || (int'(cfg.kernel_size) > MAX_KERNEL) ||
			(cfg.stride == '0) ||
			(cfg.in_width == '0) || (int'(cfg.in_width) > MAX_DIM) ||
			(cfg.in_height == '0) || (int'(cfg.in_height) > MAX_DIM) ||
			(cfg.out_width == '0) || (int'(cfg.out_width) > MAX_DIM) ||
			(cfg.out_height == '0) || (int'(cfg.out_height) > MAX_DIM);
		bad_run = bad_cfg || !rule_ok;
	end

	// sample coordinates and addresses
	always_comb begin
		ix = $signed(CO_W'(x_q) * CO_W'(cfg.stride) - CO_W'(offs) + CO_W'(cx_q));
		iy = $signed(CO_W'(y_q) * CO_W'(cfg.stride) - CO_W'(offs) + CO_W'(cy_q));
		oob = ix[CO_W-1] || iy[CO_W-1] ||
			(ix[CO_W-2:0] >= (CO_W - 1)'(cfg.in_width)) ||
			(iy[CO_W-2:0] >= (CO_W - 1)'(cfg.in_height));
		ld_addr  = {DIM_W'(head.row), DIM_W'(head.col)};
		in_addr  = {DIM_W'(iy), DIM_W'(ix)};
		og_addr  = {DIM_W'(y_q), DIM_W'(x_q)};
		acc_addr = KI_W'(cy_q) * KI_W'(MAX_KERNEL) + KI_W'(cx_q);
	end

	// saturating accumulate
	always_comb begin
		acc_val = acc_rv_q ? acc_rd_q : '0;
		acc_sum = $signed({{(SW - ACC_WIDTH){acc_val[ACC_WIDTH-1]}}, acc_val}) +
			$signed({{(SW - PW){prod_s2[PW-1]}}, prod_s2});
		if (acc_sum > ACC_HI)
			acc_sat = ACC_HI[ACC_WIDTH-1:0];
		else if (acc_sum < ACC_LO)
			acc_sat = ACC_LO[ACC_WIDTH-1:0];
		else
			acc_sat = acc_sum[ACC_WIDTH-1:0];
	end

	assign out_free = !out_valid_q || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state and handshakes
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		out_ld  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (head.op == OP_RUN) begin
						if (bad_run)
							state_d = S_ERR;
						else if (walk_empty)
							state_d = S_EMIT_RD;
						else
							state_d = S_RD;
					end
				end
			end
			S_RD:  state_d = S_MUL;
			S_MUL: state_d = S_ADD;
			S_ADD: begin
				if (tap_last && (x_q == x_end) && (y_q == y_end))
					state_d = S_EMIT_RD;
				else
					state_d = S_RD;
			end
			S_EMIT_RD: state_d = S_EMIT_WR;
			S_EMIT_WR: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = tap_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_ERR: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// walk counters, valid bits and output beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			acc_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE && pop && head.op == OP_RUN) begin
				x_q  <= CFG_W'(offs);
				y_q  <= CFG_W'(offs);
				cx_q <= '0;
				cy_q <= '0;
			end
			if (state_q == S_IDLE && pop && head.op == OP_CLEAR)
				acc_vld_q <= '0;
			if (state_q == S_ADD) begin
				acc_vld_q[acc_addr] <= 1'b1;
				if (cy_q == kl) begin
					cy_q <= '0;
					if (cx_q == kl) begin
						cx_q <= '0;
						if (x_q == x_end) begin
							x_q <= CFG_W'(offs);
							y_q <= y_q + CFG_W'(1);
						end else begin
							x_q <= x_q + CFG_W'(1);
						end
					end else begin
						cx_q <= cx_q + TAP_W'(1);
					end
				end else begin
					cy_q <= cy_q + TAP_W'(1);
				end
			end
			if (state_q == S_EMIT_WR && out_ld) begin
				if (cx_q == kl) begin
					cx_q <= '0;
					cy_q <= cy_q + TAP_W'(1);
				end else begin
					cx_q <= cx_q + TAP_W'(1);
				end
			end
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// memories and datapath
	always_ff @(posedge clk) begin
		if (pop && head.op == OP_LOAD_IN)
			in_mem[ld_addr] <= head_value;
		if (pop && head.op == OP_LOAD_OG)
			og_mem[ld_addr] <= head_value;
		in_rd_s1 <= in_mem[in_addr];
		og_rd_s1 <= og_mem[og_addr];
		oob_s1   <= oob;
		prod_s2  <= oob_s1 ? $signed(PW'(0)) : in_rd_s1 * og_rd_s1;
		acc_rd_q <= acc_mem[acc_addr];
		acc_rv_q <= acc_vld_q[acc_addr];
		if (state_q == S_ADD)
			acc_mem[acc_addr] <= acc_sat;
		if (out_ld) begin
			if (state_q == S_ERR) begin
				tap_col_q  <= '0;
				tap_row_q  <= '0;
				gradient_q <= '0;
				status_q   <= 1'b1;
				last_q     <= 1'b1;
			end else begin
				tap_col_q  <= cx_q;
				tap_row_q  <= cy_q;
				gradient_q <= acc_val;
				status_q   <= 1'b0;
				last_q     <= tap_last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign tap_col   = tap_col_q;
	assign tap_row   = tap_row_q;
	assign gradient  = gradient_q;
	assign status    = status_q;
	assign last      = last_q;

	`CWG_ASSERT_IMP(a_err_beat, out_valid && status, last && gradient == '0)
	`CWG_ASSERT_IMP(a_last_tap, out_valid && last && !status, tap_col == kl && tap_row == kl)
	`CWG_ASSERT_NXT(a_clear, pop && head.op == OP_CLEAR, acc_vld_q == '0)

endmodule

>>> src/conv_weight_gradient.sv
// single-channel 2d convolution weight gradient
// input channel (in_valid/in_stall): kind, col, row, value. kind 0 and 1 load one
// element of the input map or of the output-gradient map, kind 2 runs, kind 3
// zeroes the accumulators. output channel (out_valid/out_stall): one beat per
// kernel tap, rows outer and columns inner, last set on the final beat; a run
// whose sizes break the rule gives a single beat with status 1 instead.
// configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// must be written by the user only while the block is idle; it is not enforced.
// a four-deep queue parts the front from the back. loads and clears retire one
// per cycle while the back is idle. a run steps through a map read, a multiply
// and a saturating add into the accumulator memory for each tap of each output
// position, then an accumulator read and a write for each emitted beat; an error
// run goes straight to its status beat. a stalled output holds its beat; the
// back waits, the queue keeps taking items until it fills, then in_stall rises.
// reset empties the queue, restores register defaults and zeroes the
// accumulators through their valid bits; map contents are undefined until loaded.
module conv_weight_gradient
	import cwg_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [COL_W-1:0]      col,
	input  logic [COL_W-1:0]      row,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TAP_W-1:0]      tap_col,
	output logic [TAP_W-1:0]      tap_row,
	output logic [ACC_WIDTH-1:0]  gradient,
	output logic                  status,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_t                  cfg_q;
	head_t                 head;
	logic [DATA_WIDTH-1:0] head_value;
	logic                  pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_size <= KS_RST;
			cfg_q.stride      <= ST_RST;
			cfg_q.in_width    <= DIM_RST;
			cfg_q.in_height   <= DIM_RST;
			cfg_q.out_width   <= DIM_RST;
			cfg_q.out_height  <= DIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KERNEL: cfg_q.kernel_size <= cfg_data[KS_W-1:0];
				REG_STRIDE: cfg_q.stride      <= cfg_data[KS_W-1:0];
				REG_IN_W:   cfg_q.in_width    <= cfg_data;
				REG_IN_H:   cfg_q.in_height   <= cfg_data;
				REG_OUT_W:  cfg_q.out_width   <= cfg_data;
				REG_OUT_H:  cfg_q.out_height  <= cfg_data;
				default: ;
			endcase
		end
	end

	cwg_front #(
		.MAX_DIM    (MAX_DIM),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.col        (col),
		.row        (row),
		.value      (value),
		.head       (head),
		.head_value (head_value),
		.pop        (pop)
	);

	cwg_back #(
		.MAX_DIM    (MAX_DIM),
		.MAX_KERNEL (MAX_KERNEL),
		.DATA_WIDTH (DATA_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_value (head_value),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tap_col    (tap_col),
		.tap_row    (tap_row),
		.gradient   (gradient),
		.status     (status),
		.last       (last)
	);

endmodule

>>> tb/conv_weight_gradient_test.sv
`default_nettype none

import cwg_pkg::*;

typedef struct packed {
	logic [TAP_W-1:0] tap_col;
	logic [TAP_W-1:0] tap_row;
	logic [47:0]      gradient;
	logic             status;
	logic             last;
} grad_beat_t;

localparam logic STATUS_OK      = 1'b0;
localparam logic STATUS_SKIPPED = 1'b1;

// tracks maps, registers and accumulators, holds the beats still owed
class grad_scoreboard;
	logic [KS_W-1:0]  ksize, step;
	logic [CFG_W-1:0] iw, ih, ow, oh;
	logic signed [15:0] in_map[4096];
	logic signed [15:0] og_map[4096];
	bit in_wr[4096];
	bit og_wr[4096];
	longint acc[49];
	grad_beat_t owed[$];
	int errors, checked, runs, bad_runs, loads, clears;

	function new();
		ksize = KS_RST;
		step = ST_RST;
		iw = DIM_RST;
		ih = DIM_RST;
		ow = DIM_RST;
		oh = DIM_RST;
		foreach (acc[i]) acc[i] = 0;
		foreach (in_wr[i]) begin
			in_wr[i] = 0;
			og_wr[i] = 0;
		end
	endfunction

	function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
		case (idx)
			REG_KERNEL: ksize = d[KS_W-1:0];
			REG_STRIDE: step = d[KS_W-1:0];
			REG_IN_W: iw = d;
			REG_IN_H: ih = d;
			REG_OUT_W: ow = d;
			REG_OUT_H: oh = d;
			default: ;
		endcase
	endfunction

	// sizes in range and the size rule holds
	function bit run_legal();
		int k, offs;
		k = ksize;
		offs = k / 2;
		if (k == 0 || k > 7 || step == 0) return 0;
		if (iw == 0 || iw > 64 || ih == 0 || ih > 64) return 0;
		if (ow == 0 || ow > 64 || oh == 0 || oh > 64) return 0;
		return (int'(iw) - offs) / int'(step) >= int'(ow) - 2 * offs;
	endfunction

	function longint sat_add(longint a, longint p);
		longint hi, lo;
		hi = (64'sd1 <<< 47) - 1;
		lo = -hi - 1;
		if (p > 0 && a > hi - p) return hi;
		if (p < 0 && a < lo - p) return lo;
		return a + p;
	endfunction

	// apply one accepted item, queue the beats it owes
	function void note_item(kind_t kd, logic [5:0] c, logic [5:0] r, logic signed [15:0] v);
		int k, offs, ix, iy;
		longint g, d;
		grad_beat_t b;
		case (kd)
			KIND_LOAD_IN: begin
				in_map[r*64+c] = v;
				in_wr[r*64+c] = 1;
				loads++;
			end
			KIND_LOAD_OG: begin
				og_map[r*64+c] = v;
				og_wr[r*64+c] = 1;
				loads++;
			end
			KIND_CLEAR: begin
				foreach (acc[i]) acc[i] = 0;
				clears++;
			end
			default: begin
				runs++;
				if (!run_legal()) begin
					bad_runs++;
					b = '{tap_col: 0, tap_row: 0, gradient: 0,
						status: STATUS_SKIPPED, last: 1'b1};
					owed.push_back(b);
				end else begin
					k = ksize;
					offs = k / 2;
					for (int y = offs; y < int'(oh) - offs; y++)
						for (int x = offs; x < int'(ow) - offs; x++) begin
							g = og_map[y*64+x];
							for (int cx = 0; cx < k; cx++)
								for (int cy = 0; cy < k; cy++) begin
									ix = x * step - offs + cx;
									iy = y * step - offs + cy;
									d = (ix < 0 || iy < 0 || ix >= iw || iy >= ih) ?
										0 : in_map[iy*64+ix];
									acc[cy*7+cx] = sat_add(acc[cy*7+cx], d * g);
								end
						end
					for (int cy = 0; cy < k; cy++)
						for (int cx = 0; cx < k; cx++) begin
							b.tap_col = TAP_W'(cx);
							b.tap_row = TAP_W'(cy);
							b.gradient = acc[cy*7+cx][47:0];
							b.status = STATUS_OK;
							b.last = (cy == k - 1 && cx == k - 1);
							owed.push_back(b);
						end
				end
			end
		endcase
	endfunction

	function void check_beat(grad_beat_t got);
		grad_beat_t e;
		checked++;
		if (owed.size() == 0) begin
			errors++;
			$display("%0t: unexpected beat tap %0d,%0d gradient %h", $time,
				got.tap_col, got.tap_row, got.gradient);
			return;
		end
		e = owed.pop_front();
		if (got.tap_col !== e.tap_col) begin
			errors++;
			$display("%0t: tap_col expected %0d got %0d", $time, e.tap_col, got.tap_col);
		end
		if (got.tap_row !== e.tap_row) begin
			errors++;
			$display("%0t: tap_row expected %0d got %0d", $time, e.tap_row, got.tap_row);
		end
		if (got.gradient !== e.gradient) begin
			errors++;
			$display("%0t: gradient expected %h got %h", $time, e.gradient, got.gradient);
		end
		if (got.status !== e.status) begin
			errors++;
			$display("%0t: status expected %0d got %0d", $time, e.status, got.status);
		end
		if (got.last !== e.last) begin
			errors++;
			$display("%0t: last expected %0d got %0d", $time, e.last, got.last);
		end
	endfunction
endclass

module conv_weight_gradient_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] kind = 0;
	logic [COL_W-1:0] col = 0;
	logic [COL_W-1:0] row = 0;
	logic [15:0] value = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [TAP_W-1:0] tap_col;
	logic [TAP_W-1:0] tap_row;
	logic [47:0] gradient;
	logic status;
	logic last;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_W-1:0] cfg_data = 0;

	grad_scoreboard sb = new();
	int cycles = 0;
	int stall_left = 0;
	int sent = 0;
	bit quiet = 0;

	conv_weight_gradient uut (.*);

	// clock
	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** conv_weight_gradient: FAILED **");
			$finish;
		end
	end

	// receiver stall, short bursts with a few long ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(99) < 25) begin
			out_stall <= 1;
			stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end else begin
			out_stall <= 0;
		end
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat('{tap_col, tap_row, gradient, status, last});
	end

	function int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// one input beat, called at a rising edge
	task automatic send(kind_t kd, int c, int r, logic [15:0] v);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		kind <= kd;
		col <= COL_W'(c);
		row <= COL_W'(r);
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(kd, COL_W'(c), COL_W'(r), v);
		sent++;
	endtask

	// sender holds off until every owed beat is in and the queue has drained
	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(int k, int s, int iw, int ih, int ow, int oh);
		int vals[6];
		vals = '{k, s, iw, ih, ow, oh};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= CFG_W'(vals[i]);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.set_reg(cfg_reg_t'(i), CFG_W'(vals[i]));
		end
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// load every map entry the next run reads that has not been written yet
	task automatic prepare_maps();
		int offs, ix, iy;
		if (!sb.run_legal()) return;
		offs = sb.ksize / 2;
		for (int y = offs; y < int'(sb.oh) - offs; y++)
			for (int x = offs; x < int'(sb.ow) - offs; x++) begin
				if (!sb.og_wr[y*64+x]) send(KIND_LOAD_OG, x, y, pick_value());
				for (int cx = 0; cx < sb.ksize; cx++)
					for (int cy = 0; cy < sb.ksize; cy++) begin
						ix = x * sb.step - offs + cx;
						iy = y * sb.step - offs + cy;
						if (ix >= 0 && iy >= 0 && ix < sb.iw && iy < sb.ih &&
							!sb.in_wr[iy*64+ix])
							send(KIND_LOAD_IN, ix, iy, pick_value());
					end
			end
	endtask

	// small legal sizes, or one of them broken on purpose
	task automatic random_config(bit broken);
		int k, s, offs, ow, oh, iw, ih;
		k = ($urandom_range(4) == 0) ? $urandom_range(1, 7) : 2 * $urandom_range(0, 3) + 1;
		s = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 1;
		offs = k / 2;
		ow = 2 * offs + $urandom_range(1, 2);
		oh = 2 * offs + $urandom_range(1, 3);
		iw = offs + s * (ow - 2 * offs) + $urandom_range(0, 2);
		ih = $urandom_range(1, offs + s * (oh - 2 * offs) + 2);
		if (iw > 64) iw = 64;
		if (broken)
			case ($urandom_range(5))
				0: k = 0;
				1: s = 0;
				2: iw = 0;
				3: oh = $urandom_range(65, 127);
				4: ih = 0;
				default: iw = offs;
			endcase
		set_config(k, s, iw, ih, ow, oh);
	endtask

	initial begin
		int n, r, rand_start;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: widest maps with a single position, accumulation and clear
		quiet = 1;
		set_config(1, 1, 64, 64, 1, 1);
		send(KIND_LOAD_IN, 0, 0, 16'h8000);
		send(KIND_LOAD_OG, 0, 0, 16'h8000);
		send(KIND_RUN, 0, 0, 0);
		send(KIND_RUN, 0, 0, 0);
		send(KIND_LOAD_IN, 63, 63, 16'h7fff);
		send(KIND_LOAD_OG, 63, 63, 16'h7fff);
		send(KIND_LOAD_OG, 0, 0, 16'h7fff);
		send(KIND_RUN, 0, 0, 0);
		send(KIND_CLEAR, 0, 0, 0);
		send(KIND_RUN, 0, 0, 0);
		quiet = 0;
		// skipped runs: zero kernel, zero stride, zero and oversize dims, size rule
		wait_idle();
		set_config(0, 1, 64, 64, 1, 1);
		send(KIND_RUN, 0, 0, 0);
		wait_idle();
		set_config(7, 0, 64, 64, 7, 7);
		send(KIND_RUN, 0, 0, 0);
		wait_idle();
		set_config(1, 1, 0, 64, 1, 1);
		send(KIND_RUN, 0, 0, 0);
		wait_idle();
		set_config(1, 1, 127, 64, 1, 127);
		send(KIND_RUN, 0, 0, 0);
		wait_idle();
		set_config(1, 4, 1, 1, 64, 64);
		send(KIND_RUN, 0, 0, 0);
		// even kernel, reads past the map edge
		wait_idle();
		set_config(2, 1, 3, 1, 3, 3);
		prepare_maps();
		send(KIND_RUN, 0, 0, 0);

		// random phases
		rand_start = sent;
		while (sent - rand_start < 110) begin
			wait_idle();
			quiet = ($urandom_range(3) == 0);
			random_config($urandom_range(4) == 0);
			prepare_maps();
			n = $urandom_range(6, 14);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(99);
				if (r < 35) begin
					prepare_maps();
					send(KIND_RUN, $urandom_range(63), $urandom_range(63), pick_value());
				end else if (r < 45) begin
					send(KIND_CLEAR, $urandom_range(63), $urandom_range(63), pick_value());
				end else begin
					send(r < 72 ? KIND_LOAD_IN : KIND_LOAD_OG,
						$urandom_range(63), $urandom_range(63), pick_value());
				end
			end
		end

		quiet = 0;
		wait_idle();
		$display("covered %0d loads, %0d clears, %0d runs (%0d skipped), %0d beats checked",
			sb.loads, sb.clears, sb.runs, sb.bad_runs, sb.checked);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("** conv_weight_gradient: PASSED **");
		end else begin
			$display("** conv_weight_gradient: FAILED **");
		end
		$finish;
	end
endmodule

`default_nettype wire
